// File: rtl/itoa_pkg.sv
// Shared types, constants and helpers for the integer to ASCII formatter.
// No dependencies; used by the interfaces and the core.
package itoa_pkg;

    localparam int OpW        = 3;
    localparam int SizeW      = 2;
    localparam int ValueW     = 64;
    localparam int FieldW     = 6;
    localparam int CharW      = 8;
    localparam int Digits     = 20;             // decimal digits of a 64-bit value
    localparam int BcdW       = Digits * 4;
    localparam int DigCntW    = $clog2(Digits + 1);
    localparam int BitCntW    = $clog2(ValueW + 1);
    localparam int DefMaxWidth = 32;

    typedef enum logic [OpW-1:0] {
        OP_SDEC  = 3'd0,
        OP_UDEC  = 3'd1,
        OP_LHEX  = 3'd2,
        OP_UHEX  = 3'd3,
        OP_PTR   = 3'd4,
        OP_CHAR  = 3'd5
    } op_t;

    typedef enum logic [SizeW-1:0] {
        SZ_8  = 2'd0,
        SZ_16 = 2'd1,
        SZ_32 = 2'd2,
        SZ_64 = 2'd3
    } size_t;

    localparam logic [CharW-1:0] ChZero  = 8'h30;
    localparam logic [CharW-1:0] ChSpace = 8'h20;
    localparam logic [CharW-1:0] ChMinus = 8'h2D;
    localparam logic [CharW-1:0] ChLowA  = 8'h61;
    localparam logic [CharW-1:0] ChUpA   = 8'h41;

    // One digit (0..15) to its ASCII symbol.
    function automatic logic [CharW-1:0] digit_char(input logic [3:0] d, input logic upper);
        logic [CharW-1:0] base;
        begin
            base = upper ? ChUpA : ChLowA;
            if (d < 4'd10)
                digit_char = ChZero + {4'b0, d};
            else
                digit_char = base + {4'b0, d} - 8'd10;
        end
    endfunction

    // Add-3 correction of one BCD digit before a shift.
    function automatic logic [3:0] dabble(input logic [3:0] d);
        begin
            dabble = (d >= 4'd5) ? d + 4'd3 : d;
        end
    endfunction

endpackage

// File: rtl/itoa_if.sv
// Valid/ready channels of the formatter: argument items in, text items out.
// Depends on itoa_pkg for field widths.
interface itoa_arg_if;
    logic                          valid;
    logic                          ready;
    logic [itoa_pkg::OpW-1:0]      op;
    logic [itoa_pkg::SizeW-1:0]    operand_size;
    logic [itoa_pkg::ValueW-1:0]   value;
    logic [itoa_pkg::FieldW-1:0]   field_width;
    logic                          zero_pad;

    modport source (output valid, op, operand_size, value, field_width, zero_pad,
                    input ready);
    modport sink   (input valid, op, operand_size, value, field_width, zero_pad,
                    output ready);
endinterface

interface itoa_text_if;
    logic                          valid;
    logic                          ready;
    logic [itoa_pkg::CharW-1:0]    out_char;
    logic                          last;

    modport source (output valid, out_char, last, input ready);
    modport sink   (input valid, out_char, last, output ready);
endinterface

// File: rtl/integer_to_ascii_formatter_core.sv
// Integer to ASCII formatter core: bit-serial BCD conversion and character output.
// Depends on itoa_pkg and the channel interfaces in itoa_if.sv.
//
// Usage:
//   arg  (sink)   : one item = op, operand_size, value, field_width, zero_pad.
//   text (source) : one item per character, most significant first; last marks
//                   the final character of an argument. Unused op codes give none.
// Timing, one argument at a time (arg.ready is high only when the core is idle):
//   Decimal: operand bits are shifted through a 20-digit BCD register with
//   add-3 correction, one bit per cycle: 8, 16, 32 or 64 bits by operand size.
//   All numeric kinds then drop leading zero digits one per cycle (20 minus the
//   digit count, at most 19) and then start output, which runs one character per
//   cycle while text.ready is high: sign, padding (none for signed decimal), digits.
//   arg.ready rises at the edge where the last character enters the output register.
// The output register lets the core continue while a character waits; when
//   text.ready is low and a character waits, ST_EMIT holds until it is taken.
// Reset (rst_n low, asynchronous) returns to idle and empties the output register.
module integer_to_ascii_formatter_core #(
    parameter int MAX_WIDTH = itoa_pkg::DefMaxWidth
) (
    input  logic          clk,
    input  logic          rst_n,
    itoa_arg_if.sink      arg,
    itoa_text_if.source   text
);

    localparam int PadW = $clog2(MAX_WIDTH + 1);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_CONV = 4'b0010,
        ST_NORM = 4'b0100,
        ST_EMIT = 4'b1000
    } state_t;

    state_t                               state_reg, state_next;
    logic [itoa_pkg::BcdW-1:0]            bcd_reg, bcd_next;
    logic [itoa_pkg::ValueW-1:0]          bin_reg, bin_next;
    logic [itoa_pkg::BitCntW-1:0]         cnt_reg, cnt_next;
    logic [itoa_pkg::DigCntW-1:0]         nd_reg, nd_next;
    logic [PadW-1:0]                      pad_reg, pad_next;
    logic [PadW-1:0]                      width_reg, width_next;
    logic                                 sign_reg, sign_next;
    logic                                 zpad_reg, zpad_next;
    logic                                 upper_reg, upper_next;
    logic                                 chr_reg, chr_next;
    logic                                 out_valid_reg, out_valid_next;
    logic [itoa_pkg::CharW-1:0]           out_char_reg, out_char_next;
    logic                                 out_last_reg, out_last_next;

    // Load-time operand shaping
    logic [itoa_pkg::ValueW-1:0]          sx;
    logic [itoa_pkg::ValueW-1:0]          masked;
    logic [itoa_pkg::ValueW-1:0]          mag;
    logic [itoa_pkg::ValueW-1:0]          src;
    logic [itoa_pkg::ValueW-1:0]          aligned;
    logic [itoa_pkg::BitCntW-1:0]         nbits;
    logic                                 neg;
    logic [PadW-1:0]                      width_sat;
    logic [itoa_pkg::BcdW-1:0]            bcd_adj;
    logic                                 slot_free;
    logic [PadW-1:0]                      nd_ext;

    always_comb
    begin
        unique case (itoa_pkg::size_t'(arg.operand_size))
            itoa_pkg::SZ_8:
            begin
                masked = {56'b0, arg.value[7:0]};
                sx     = {{56{arg.value[7]}}, arg.value[7:0]};
                nbits  = itoa_pkg::BitCntW'(8);
            end
            itoa_pkg::SZ_16:
            begin
                masked = {48'b0, arg.value[15:0]};
                sx     = {{48{arg.value[15]}}, arg.value[15:0]};
                nbits  = itoa_pkg::BitCntW'(16);
            end
            itoa_pkg::SZ_32:
            begin
                masked = {32'b0, arg.value[31:0]};
                sx     = {{32{arg.value[31]}}, arg.value[31:0]};
                nbits  = itoa_pkg::BitCntW'(32);
            end
            default:
            begin
                masked = arg.value;
                sx     = arg.value;
                nbits  = itoa_pkg::BitCntW'(64);
            end
        endcase
        neg = sx[63];
        mag = neg ? (~sx + 64'd1) : sx;
        src = (itoa_pkg::op_t'(arg.op) == itoa_pkg::OP_SDEC) ? mag : masked;
        // magnitude fits the operand size, so align it to the top of the shifter
        unique case (itoa_pkg::size_t'(arg.operand_size))
            itoa_pkg::SZ_8:  aligned = {src[7:0], 56'b0};
            itoa_pkg::SZ_16: aligned = {src[15:0], 48'b0};
            itoa_pkg::SZ_32: aligned = {src[31:0], 32'b0};
            default:         aligned = src;
        endcase
        width_sat = (32'(arg.field_width) > MAX_WIDTH) ? PadW'(MAX_WIDTH)
                                                       : PadW'(arg.field_width);
    end

    always_comb
    begin
        for (int i = 0; i < itoa_pkg::Digits; i++)
            bcd_adj[4*i +: 4] = itoa_pkg::dabble(bcd_reg[4*i +: 4]);
    end

    assign slot_free = !out_valid_reg || text.ready;
    assign nd_ext    = PadW'(nd_reg);
    assign arg.ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        bcd_next       = bcd_reg;
        bin_next       = bin_reg;
        cnt_next       = cnt_reg;
        nd_next        = nd_reg;
        pad_next       = pad_reg;
        width_next     = width_reg;
        sign_next      = sign_reg;
        zpad_next      = zpad_reg;
        upper_next     = upper_reg;
        chr_next       = chr_reg;
        out_valid_next = out_valid_reg && !text.ready;
        out_char_next  = out_char_reg;
        out_last_next  = out_last_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (arg.valid)
                begin
                    nd_next    = itoa_pkg::DigCntW'(itoa_pkg::Digits);
                    pad_next   = '0;
                    width_next = width_sat;
                    zpad_next  = arg.zero_pad;
                    sign_next  = 1'b0;
                    chr_next   = 1'b0;
                    upper_next = 1'b0;
                    unique case (arg.op)
                        itoa_pkg::OP_SDEC, itoa_pkg::OP_UDEC:
                        begin
                            sign_next  = (itoa_pkg::op_t'(arg.op) == itoa_pkg::OP_SDEC)
                                         && neg;
                            width_next = (itoa_pkg::op_t'(arg.op) == itoa_pkg::OP_SDEC)
                                         ? '0 : width_sat;
                            bcd_next   = '0;
                            bin_next   = aligned;
                            cnt_next   = nbits;
                            state_next = ST_CONV;
                        end
                        itoa_pkg::OP_LHEX, itoa_pkg::OP_UHEX:
                        begin
                            upper_next = (itoa_pkg::op_t'(arg.op) == itoa_pkg::OP_UHEX);
                            bcd_next   = {16'b0, masked};
                            state_next = ST_NORM;
                        end
                        itoa_pkg::OP_PTR:
                        begin
                            // eight upper-case digits: same as zero-padded hex, width 8
                            upper_next = 1'b1;
                            zpad_next  = 1'b1;
                            width_next = PadW'(8);
                            bcd_next   = {48'b0, arg.value[31:0]};
                            state_next = ST_NORM;
                        end
                        itoa_pkg::OP_CHAR:
                        begin
                            chr_next   = 1'b1;
                            bcd_next   = {arg.value[7:0], 72'b0};
                            state_next = ST_EMIT;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_CONV:
            begin
                bcd_next = {bcd_adj[itoa_pkg::BcdW-2:0], bin_reg[itoa_pkg::ValueW-1]};
                bin_next = {bin_reg[itoa_pkg::ValueW-2:0], 1'b0};
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == itoa_pkg::BitCntW'(1))
                    state_next = ST_NORM;
            end
            ST_NORM:
            begin
                if (nd_reg > itoa_pkg::DigCntW'(1)
                    && bcd_reg[itoa_pkg::BcdW-1 -: 4] == 4'd0)
                begin
                    bcd_next = {bcd_reg[itoa_pkg::BcdW-5:0], 4'b0};
                    nd_next  = nd_reg - 1'b1;
                end
                else
                begin
                    pad_next   = (width_reg > nd_ext) ? width_reg - nd_ext : '0;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    priority if (chr_reg)
                    begin
                        out_char_next = bcd_reg[itoa_pkg::BcdW-1 -: 8];
                        out_last_next = 1'b1;
                        chr_next      = 1'b0;
                        state_next    = ST_IDLE;
                    end
                    else if (sign_reg)
                    begin
                        out_char_next = itoa_pkg::ChMinus;
                        out_last_next = 1'b0;
                        sign_next     = 1'b0;
                    end
                    else if (pad_reg != '0)
                    begin
                        out_char_next = zpad_reg ? itoa_pkg::ChZero : itoa_pkg::ChSpace;
                        out_last_next = 1'b0;
                        pad_next      = pad_reg - 1'b1;
                    end
                    else
                    begin
                        out_char_next = itoa_pkg::digit_char(
                                            bcd_reg[itoa_pkg::BcdW-1 -: 4], upper_reg);
                        out_last_next = (nd_reg == itoa_pkg::DigCntW'(1));
                        bcd_next      = {bcd_reg[itoa_pkg::BcdW-5:0], 4'b0};
                        nd_next       = nd_reg - 1'b1;
                        if (nd_reg == itoa_pkg::DigCntW'(1))
                            state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            sign_reg      <= 1'b0;
            chr_reg       <= 1'b0;
            nd_reg        <= '0;
            pad_reg       <= '0;
            cnt_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            sign_reg      <= sign_next;
            chr_reg       <= chr_next;
            nd_reg        <= nd_next;
            pad_reg       <= pad_next;
            cnt_reg       <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bcd_reg      <= bcd_next;
        bin_reg      <= bin_next;
        width_reg    <= width_next;
        zpad_reg     <= zpad_next;
        upper_reg    <= upper_next;
        out_char_reg <= out_char_next;
        out_last_reg <= out_last_next;
    end

    assign text.valid    = out_valid_reg;
    assign text.out_char = out_char_reg;
    assign text.last     = out_last_reg;

    // A char argument goes straight to the output sequencer.
    a_char_to_emit: assert property (@(posedge clk) disable iff (!rst_n)
        arg.valid && arg.ready && arg.op == itoa_pkg::OP_CHAR |=> state_reg == ST_EMIT)
        else $error("char item did not go to emit");

    // Digit count never runs out while normalizing.
    a_norm_digits: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_NORM |-> nd_reg != '0)
        else $error("normalize with no digits");

    // Once sign and padding are done, at least one digit remains to emit.
    a_emit_digits: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_EMIT && !chr_reg && !sign_reg && pad_reg == '0 |-> nd_reg != '0)
        else $error("emit with no digits left");

    // Conversion shift count is nonzero while converting.
    a_conv_count: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_CONV |-> cnt_reg != '0)
        else $error("conversion with zero bit count");

endmodule

// File: dv/tb.sv
// Self-checking bench for integer_to_ascii_formatter_core: formats each accepted
// argument in a local model and checks every text item in order against it.
// Depends on itoa_pkg and the channel interfaces in rtl/itoa_if.sv.
module tb;

    localparam int MaxWidth   = itoa_pkg::DefMaxWidth;
    localparam int CycleLimit = 400000;
    localparam int TailCycles = 200;
    localparam int HoldCycles = 400;
    localparam int PhaseArgs  = 34;

    // op codes the block has no conversion for
    localparam logic [itoa_pkg::OpW-1:0] OP_RSVD6 = 3'd6;
    localparam logic [itoa_pkg::OpW-1:0] OP_RSVD7 = 3'd7;

    typedef struct {
        logic [itoa_pkg::OpW-1:0]    op;
        logic [itoa_pkg::SizeW-1:0]  size;
        logic [itoa_pkg::ValueW-1:0] value;
        logic [itoa_pkg::FieldW-1:0] width;
        logic                        zpad;
    } arg_item_t;

    typedef struct packed {
        logic [itoa_pkg::CharW-1:0] ch;
        logic                       last;
    } text_item_t;

    class text_scoreboard;
        text_item_t                 pending_chars[$];
        logic [itoa_pkg::CharW-1:0] digit_buf[$];
        string                      lower_digits = "0123456789abcdef";
        string                      upper_digits = "0123456789ABCDEF";
        int                         errors;
        int                         args_seen;
        int                         chars_seen;

        // least significant digit first into digit_buf
        function void push_digits(logic [63:0] v, logic [63:0] base, logic upper);
            logic [3:0] d;
            do
            begin
                d = 4'(v % base);
                digit_buf.push_back(upper ? upper_digits[d] : lower_digits[d]);
                v = v / base;
            end
            while (v != 0);
        endfunction

        function void note_arg(arg_item_t a);
            logic [63:0] m;
            logic [63:0] v;
            logic        neg;
            int          w;
            digit_buf = {};
            args_seen++;
            w = (a.width > MaxWidth) ? MaxWidth : int'(a.width);
            case (a.size)
                itoa_pkg::SZ_8:  m = 64'hFF;
                itoa_pkg::SZ_16: m = 64'hFFFF;
                itoa_pkg::SZ_32: m = 64'hFFFF_FFFF;
                default:         m = '1;
            endcase
            case (a.op)
                itoa_pkg::OP_SDEC:
                begin
                    v = a.value & m;
                    if (a.size != itoa_pkg::SZ_64 && (v & ((m >> 1) + 64'd1)) != 0)
                        v = v | ~m;
                    neg = v[63];
                    if (neg)
                        v = -v;
                    push_digits(v, 64'd10, 1'b0);
                    if (neg)
                        digit_buf.push_back(itoa_pkg::ChMinus);
                end
                itoa_pkg::OP_UDEC, itoa_pkg::OP_LHEX, itoa_pkg::OP_UHEX:
                begin
                    push_digits(a.value & m, (a.op == itoa_pkg::OP_UDEC) ? 64'd10 : 64'd16,
                                a.op == itoa_pkg::OP_UHEX);
                    while (digit_buf.size() < w)
                        digit_buf.push_back(a.zpad ? itoa_pkg::ChZero : itoa_pkg::ChSpace);
                end
                itoa_pkg::OP_PTR:
                begin
                    push_digits({32'b0, a.value[31:0]}, 64'd16, 1'b1);
                    while (digit_buf.size() < 8)
                        digit_buf.push_back(itoa_pkg::ChZero);
                end
                itoa_pkg::OP_CHAR:
                    digit_buf.push_back(a.value[7:0]);
                default:
                    ;
            endcase
            for (int k = digit_buf.size() - 1; k >= 0; k--)
                pending_chars.push_back('{ch: digit_buf[k], last: (k == 0)});
        endfunction

        function void check_char(logic [itoa_pkg::CharW-1:0] ch, logic last);
            text_item_t want;
            chars_seen++;
            if (pending_chars.size() == 0)
            begin
                $error("out_char: expected none pending, actual 0x%02h (last %0b)", ch, last);
                errors++;
                return;
            end
            want = pending_chars.pop_front();
            if (ch !== want.ch)
            begin
                $error("out_char: expected 0x%02h, actual 0x%02h", want.ch, ch);
                errors++;
            end
            if (last !== want.last)
            begin
                $error("last: expected %0b, actual %0b", want.last, last);
                errors++;
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;
    int   cycles;
    int   tx_idle_pct;
    int   rx_stall_pct;
    bit   hold_req;
    bit   hold_done;
    int   hold_left;

    itoa_arg_if  arg();
    itoa_text_if text();

    text_scoreboard sb = new();

    integer_to_ascii_formatter_core dut (
        .clk   (clk),
        .rst_n (rst_n),
        .arg   (arg),
        .text  (text)
    );

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CycleLimit)
        begin
            $display("tb: FAIL");
            $finish;
        end
    end

    always @(posedge clk)
        if (rst_n && text.valid && text.ready)
            sb.check_char(text.out_char, text.last);

    // receiver: random stalls, plus one long hold-off on request
    initial
    begin
        text.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req && !hold_done)
            begin
                hold_done = 1'b1;
                hold_left = HoldCycles;
            end
            if (!rst_n)
                text.ready = 1'b0;
            else if (hold_left > 0)
            begin
                hold_left--;
                text.ready = 1'b0;
            end
            else
                text.ready = ($urandom_range(99) >= rx_stall_pct);
        end
    end

    function automatic logic [63:0] random_value();
        logic [63:0] v;
        case ($urandom_range(5))
            0: v = 64'($urandom_range(20));
            1: v = 64'd1 << $urandom_range(63);
            2: v = ({$urandom, $urandom} & ~(64'd1 << $urandom_range(63))) | 64'h80;
            3: v = '1 << $urandom_range(63);
            default: v = {$urandom, $urandom};
        endcase
        return v;
    endfunction

    function automatic arg_item_t random_arg();
        arg_item_t a;
        a.op    = ($urandom_range(99) < 5) ? 3'($urandom_range(6, 7)) : 3'($urandom_range(5));
        a.size  = 2'($urandom_range(3));
        a.value = random_value();
        a.width = ($urandom_range(9) == 0) ? 6'($urandom_range(33, 63)) : 6'($urandom_range(32));
        a.zpad  = 1'($urandom_range(1));
        return a;
    endfunction

    function automatic arg_item_t make_arg(logic [itoa_pkg::OpW-1:0] op,
                                           logic [itoa_pkg::SizeW-1:0] size,
                                           logic [63:0] value,
                                           logic [itoa_pkg::FieldW-1:0] width,
                                           logic zpad);
        arg_item_t a;
        a.op    = op;
        a.size  = size;
        a.value = value;
        a.width = width;
        a.zpad  = zpad;
        return a;
    endfunction

    task automatic send_arg(arg_item_t a);
        arg_item_t junk;
        @(negedge clk);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            junk = random_arg();
            arg.valid        = 1'b0;
            arg.op           = junk.op;
            arg.operand_size = junk.size;
            arg.value        = junk.value;
            arg.field_width  = junk.width;
            arg.zero_pad     = junk.zpad;
            @(negedge clk);
        end
        arg.valid        = 1'b1;
        arg.op           = a.op;
        arg.operand_size = a.size;
        arg.value        = a.value;
        arg.field_width  = a.width;
        arg.zero_pad     = a.zpad;
        do
            @(posedge clk);
        while (!arg.ready);
        sb.note_arg(a);
    endtask

    task automatic run_phase(int tx_pct, int rx_pct);
        arg_item_t a;
        int        counted;
        tx_idle_pct  = tx_pct;
        rx_stall_pct = rx_pct;
        counted      = 0;
        while (counted < PhaseArgs)
        begin
            a = random_arg();
            send_arg(a);
            if (a.op != OP_RSVD6 && a.op != OP_RSVD7)
                counted++;
        end
    endtask

    initial
    begin
        arg_item_t directed[$];
        rst_n            = 1'b0;
        tx_idle_pct      = 0;
        rx_stall_pct     = 0;
        hold_req         = 1'b0;
        arg.valid        = 1'b0;
        arg.op           = itoa_pkg::OP_SDEC;
        arg.operand_size = itoa_pkg::SZ_8;
        arg.value        = '0;
        arg.field_width  = '0;
        arg.zero_pad     = 1'b0;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;

        // sign boundaries per size, most negative, masking of upper bits
        directed.push_back(make_arg(itoa_pkg::OP_SDEC, itoa_pkg::SZ_8,
                                    64'h80, 6'd0, 1'b0));
        directed.push_back(make_arg(itoa_pkg::OP_SDEC, itoa_pkg::SZ_8,
                                    64'hDEAD_BEEF_FFFF_FF7F, 6'd9, 1'b1));
        directed.push_back(make_arg(itoa_pkg::OP_SDEC, itoa_pkg::SZ_16,
                                    64'h8000, 6'd0, 1'b0));
        directed.push_back(make_arg(itoa_pkg::OP_SDEC, itoa_pkg::SZ_32,
                                    64'h8000_0000, 6'd63, 1'b1));
        directed.push_back(make_arg(itoa_pkg::OP_SDEC, itoa_pkg::SZ_64,
                                    64'h8000_0000_0000_0000, 6'd0, 1'b0));
        directed.push_back(make_arg(itoa_pkg::OP_SDEC, itoa_pkg::SZ_64,
                                    '1, 6'd0, 1'b0));
        directed.push_back(make_arg(itoa_pkg::OP_SDEC, itoa_pkg::SZ_64,
                                    64'h7FFF_FFFF_FFFF_FFFF, 6'd0, 1'b0));
        directed.push_back(make_arg(itoa_pkg::OP_SDEC, itoa_pkg::SZ_32,
                                    64'h0, 6'd20, 1'b1));
        directed.push_back(make_arg(itoa_pkg::OP_UDEC, itoa_pkg::SZ_64,
                                    '1, 6'd0, 1'b0));
        directed.push_back(make_arg(itoa_pkg::OP_UDEC, itoa_pkg::SZ_8,
                                    64'h0, 6'd5, 1'b1));
        directed.push_back(make_arg(itoa_pkg::OP_UDEC, itoa_pkg::SZ_16,
                                    64'hFFFF_FFFF, 6'd63, 1'b0));
        directed.push_back(make_arg(itoa_pkg::OP_UDEC, itoa_pkg::SZ_32,
                                    64'h1234_5678_9ABC_DEF0, 6'd33, 1'b1));
        directed.push_back(make_arg(itoa_pkg::OP_LHEX, itoa_pkg::SZ_64,
                                    '1, 6'd32, 1'b1));
        directed.push_back(make_arg(itoa_pkg::OP_LHEX, itoa_pkg::SZ_8,
                                    64'h0, 6'd0, 1'b0));
        directed.push_back(make_arg(itoa_pkg::OP_UHEX, itoa_pkg::SZ_16,
                                    64'hAB_CDEF, 6'd40, 1'b0));
        directed.push_back(make_arg(itoa_pkg::OP_UHEX, itoa_pkg::SZ_32,
                                    64'hFEDC_BA98, 6'd3, 1'b1));
        directed.push_back(make_arg(itoa_pkg::OP_PTR, itoa_pkg::SZ_8,
                                    64'hFFFF_FFFF_0000_00AB, 6'd20, 1'b0));
        directed.push_back(make_arg(itoa_pkg::OP_PTR, itoa_pkg::SZ_64,
                                    64'h0, 6'd0, 1'b1));
        directed.push_back(make_arg(itoa_pkg::OP_PTR, itoa_pkg::SZ_16,
                                    64'h1_DEAD_BEEF, 6'd63, 1'b1));
        directed.push_back(make_arg(itoa_pkg::OP_CHAR, itoa_pkg::SZ_64,
                                    64'hFFFF_FF00, 6'd31, 1'b1));
        directed.push_back(make_arg(itoa_pkg::OP_CHAR, itoa_pkg::SZ_8,
                                    '1, 6'd0, 1'b0));
        directed.push_back(make_arg(OP_RSVD6, itoa_pkg::SZ_32, '1, 6'd63, 1'b1));
        directed.push_back(make_arg(OP_RSVD7, itoa_pkg::SZ_8, 64'h0, 6'd0, 1'b0));
        directed.push_back(make_arg(itoa_pkg::OP_CHAR, itoa_pkg::SZ_32,
                                    64'h41, 6'd0, 1'b0));
        foreach (directed[i])
            send_arg(directed[i]);

        // back-to-back with a long receiver hold-off so the core backs up
        hold_req = 1'b1;
        run_phase(0, 0);
        run_phase(77, 0);
        run_phase(0, 77);
        run_phase(26, 26);

        @(negedge clk);
        arg.valid = 1'b0;
        while (sb.pending_chars.size() != 0)
            @(posedge clk);
        repeat (TailCycles) @(posedge clk);

        $display("tb: %0d arguments formatted (all kinds, sizes, widths, pads), %0d characters",
                 sb.args_seen, sb.chars_seen);
        $display("tb: idle/stall mixes and one long output hold-off; %0d mismatches",
                 sb.errors);
        if (sb.errors == 0 && sb.pending_chars.size() == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end
endmodule
